// ----- hw/rtl/itrt_pkg.sv -----
// itrt_pkg: shared types, constants and lookups for the integer to radix text block
// used by itrt_div, itrt_cell and integer_to_radix_text_top; no dependencies
`timescale 1ns / 1ps

package itrt_pkg;

    localparam int WordBits   = 32;
    localparam int RadixBits  = 6;
    localparam int CharBits   = 8;
    localparam int CfgIdxBits = 8;
    localparam int CfgDatBits = 8;
    localparam int StackDepth = WordBits;
    localparam int CntBits    = $clog2(StackDepth + 1);

    localparam logic [RadixBits-1:0] RadixMin   = RadixBits'(2);
    localparam logic [RadixBits-1:0] RadixMax   = RadixBits'(36);
    localparam logic [RadixBits-1:0] RadixTen   = RadixBits'(10);
    localparam logic [RadixBits-1:0] RadixReset = RadixBits'(10);

    localparam logic [CfgIdxBits-1:0] CfgRadix  = CfgIdxBits'(0);
    localparam logic [CfgIdxBits-1:0] CfgSigned = CfgIdxBits'(1);

    localparam logic [CharBits-1:0] CharZero   = 8'h30;
    localparam logic [CharBits-1:0] CharLetter = 8'h37;  // 'A' minus ten
    localparam logic [CharBits-1:0] CharMinus  = 8'h2D;

    // floor(2^WordBits / d), entries below two repeat the base-two value
    localparam logic [63:0] Pow = 64'd1 << WordBits;
    localparam logic [WordBits-1:0] Recip [0:36] = '{
        WordBits'(Pow / 64'd2),  WordBits'(Pow / 64'd2),  WordBits'(Pow / 64'd2),
        WordBits'(Pow / 64'd3),  WordBits'(Pow / 64'd4),  WordBits'(Pow / 64'd5),
        WordBits'(Pow / 64'd6),  WordBits'(Pow / 64'd7),  WordBits'(Pow / 64'd8),
        WordBits'(Pow / 64'd9),  WordBits'(Pow / 64'd10), WordBits'(Pow / 64'd11),
        WordBits'(Pow / 64'd12), WordBits'(Pow / 64'd13), WordBits'(Pow / 64'd14),
        WordBits'(Pow / 64'd15), WordBits'(Pow / 64'd16), WordBits'(Pow / 64'd17),
        WordBits'(Pow / 64'd18), WordBits'(Pow / 64'd19), WordBits'(Pow / 64'd20),
        WordBits'(Pow / 64'd21), WordBits'(Pow / 64'd22), WordBits'(Pow / 64'd23),
        WordBits'(Pow / 64'd24), WordBits'(Pow / 64'd25), WordBits'(Pow / 64'd26),
        WordBits'(Pow / 64'd27), WordBits'(Pow / 64'd28), WordBits'(Pow / 64'd29),
        WordBits'(Pow / 64'd30), WordBits'(Pow / 64'd31), WordBits'(Pow / 64'd32),
        WordBits'(Pow / 64'd33), WordBits'(Pow / 64'd34), WordBits'(Pow / 64'd35),
        WordBits'(Pow / 64'd36)
    };

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_PUSH,
        OP_POP
    } t_stack_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_START,
        S_DIV_WAIT,
        S_SIGN,
        S_EMIT
    } t_state;

    function automatic logic [CharBits-1:0] digit_char(input logic [RadixBits-1:0] d);
        logic [CharBits-1:0] c;
        if (d < RadixTen) begin
            c = CharZero + CharBits'(d);
        end else begin
            c = CharLetter + CharBits'(d);
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/itrt_div.sv -----
// itrt_div: divides a word by a small radix through a reciprocal multiply and one correction
// depends on itrt_pkg; result is valid in the cycle after start
`timescale 1ns / 1ps

module itrt_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [itrt_pkg::WordBits-1:0]  i_dividend,
    input  logic [itrt_pkg::RadixBits-1:0] i_divisor,
    output logic                           o_done,
    output logic [itrt_pkg::WordBits-1:0]  o_quotient,
    output logic [itrt_pkg::RadixBits-1:0] o_remainder
);
    import itrt_pkg::*;

    logic                   r_busy;
    logic [WordBits-1:0]    r_num;
    logic [RadixBits-1:0]   r_den;
    logic [2*WordBits-1:0]  r_prod;

    logic [WordBits-1:0]    w_q_est;
    logic [WordBits-1:0]    w_qd;
    logic [WordBits-1:0]    w_rem_raw;
    logic [WordBits-1:0]    w_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_dividend;
            r_den  <= i_divisor;
            r_prod <= {{WordBits{1'b0}}, i_dividend} * {{WordBits{1'b0}}, Recip[i_divisor]};
        end
    end

    // estimate is at most one below the true quotient
    always_comb begin
        w_q_est   = r_prod[2*WordBits-1:WordBits];
        w_qd      = WordBits'(w_q_est * WordBits'(r_den));
        w_rem_raw = r_num - w_qd;
        if (w_rem_raw >= WordBits'(r_den)) begin
            o_quotient = w_q_est + WordBits'(1);
            w_rem      = w_rem_raw - WordBits'(r_den);
        end else begin
            o_quotient = w_q_est;
            w_rem      = w_rem_raw;
        end
        o_remainder = w_rem[RadixBits-1:0];
    end

    assign o_done = r_busy;

endmodule

// ----- hw/rtl/itrt_cell.sv -----
// itrt_cell: one digit slot of the digit stack, shifts toward either neighbor
// depends on itrt_pkg for the stack operation type
`timescale 1ns / 1ps

module itrt_cell (
    input  logic                           i_clk,
    input  itrt_pkg::t_stack_op            i_op,
    input  logic [itrt_pkg::RadixBits-1:0] i_from_left,
    input  logic [itrt_pkg::RadixBits-1:0] i_from_right,
    output logic [itrt_pkg::RadixBits-1:0] o_digit
);
    import itrt_pkg::*;

    logic [RadixBits-1:0] r_digit;

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_PUSH: r_digit <= i_from_left;
            OP_POP:  r_digit <= i_from_right;
            default: r_digit <= r_digit;
        endcase
    end

    assign o_digit = r_digit;

endmodule

// ----- hw/rtl/integer_to_radix_text_top.sv -----
// integer_to_radix_text_top: converts words to ascii digit text in a configurable base
// depends on itrt_pkg, itrt_div and itrt_cell
`timescale 1ns / 1ps

// usage:
//   slave stream takes one 32-bit word per transfer (tdata = value)
//   master stream returns one ascii character per transfer, most significant digit
//   first, tdata = text_char, tlast marks the final character of the number
//   config channel writes register index 0 (radix, data[5:0]) or 1 (signed_mode,
//   data[0]); writes are always ready and must be made by the user while the block
//   is idle; the block itself does not enforce this
// timing:
//   one word is handled at a time; tready on the slave side is high only when idle
//   digit extraction runs through the reciprocal divider as a multiply step and then
//   a correction step; the digits are pushed into a row of shifting cells that pop
//   them back most significant first
//   the output register keeps taking characters while the receiver takes them;
//   a stall on the master side simply holds the current character
//   reset sets radix to ten, signed mode on, and leaves the block idle

module integer_to_radix_text_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave stream, tdata: value[31:0]
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [itrt_pkg::WordBits-1:0]   i_s_axis_tdata,
    // master stream, tdata: text_char[7:0]
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [itrt_pkg::CharBits-1:0]   o_m_axis_tdata,
    output logic                            o_m_axis_tlast,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [itrt_pkg::CfgIdxBits-1:0] i_cfg_index,
    input  logic [itrt_pkg::CfgDatBits-1:0] i_cfg_data
);
    import itrt_pkg::*;

    logic [RadixBits-1:0] r_radix;
    logic                 r_signed;
    t_state               r_state, n_state;
    logic [WordBits-1:0]  r_mag, n_mag;
    logic [CntBits-1:0]   r_cnt, n_cnt;
    logic                 r_neg, n_neg;
    logic                 r_out_valid, n_out_valid;
    logic [CharBits-1:0]  r_out_char, n_out_char;
    logic                 r_out_last, n_out_last;

    logic [RadixBits-1:0] w_base;
    logic                 w_slot_free;
    logic                 w_in_neg;
    t_stack_op            w_op;
    logic                 w_div_start;
    logic                 w_div_done;
    logic [WordBits-1:0]  w_div_quot;
    logic [RadixBits-1:0] w_div_rem;
    logic [RadixBits-1:0] w_cell [0:StackDepth-1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= RadixReset;
            r_signed <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CfgRadix:  r_radix  <= i_cfg_data[RadixBits-1:0];
                CfgSigned: r_signed <= i_cfg_data[0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        if (r_radix < RadixMin) begin
            w_base = RadixMin;
        end else if (r_radix > RadixMax) begin
            w_base = RadixMax;
        end else begin
            w_base = r_radix;
        end
    end

    itrt_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (r_mag),
        .i_divisor   (w_base),
        .o_done      (w_div_done),
        .o_quotient  (w_div_quot),
        .o_remainder (w_div_rem)
    );

    // digit stack: cell 0 is the top, pushes move toward the end of the row
    for (genvar g = 0; g < StackDepth; g++) begin : g_cell
        logic [RadixBits-1:0] w_left;
        logic [RadixBits-1:0] w_right;
        if (g == 0) begin : g_head
            assign w_left = w_div_rem;
        end else begin : g_body
            assign w_left = w_cell[g-1];
        end
        if (g == StackDepth - 1) begin : g_tail
            assign w_right = w_cell[g];
        end else begin : g_inner
            assign w_right = w_cell[g+1];
        end
        itrt_cell u_cell (
            .i_clk        (i_clk),
            .i_op         (w_op),
            .i_from_left  (w_left),
            .i_from_right (w_right),
            .o_digit      (w_cell[g])
        );
    end

    assign w_slot_free = !r_out_valid || i_m_axis_tready;
    assign w_in_neg    = r_signed && (w_base == RadixTen) && i_s_axis_tdata[WordBits-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_neg       <= 1'b0;
            r_mag       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_neg       <= n_neg;
            r_mag       <= n_mag;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_cnt       = r_cnt;
        n_neg       = r_neg;
        n_out_valid = w_slot_free ? 1'b0 : r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        w_op        = OP_HOLD;
        w_div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_neg   = w_in_neg;
                    n_mag   = w_in_neg ? (~i_s_axis_tdata + WordBits'(1)) : i_s_axis_tdata;
                    n_cnt   = '0;
                    n_state = S_DIV_START;
                end
            end
            S_DIV_START: begin
                w_div_start = 1'b1;
                n_state     = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (w_div_done) begin
                    w_op  = OP_PUSH;
                    n_cnt = r_cnt + CntBits'(1);
                    n_mag = w_div_quot;
                    if (w_div_quot == '0) begin
                        n_state = r_neg ? S_SIGN : S_EMIT;
                    end else begin
                        n_state = S_DIV_START;
                    end
                end
            end
            S_SIGN: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CharMinus;
                    n_out_last  = 1'b0;
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = digit_char(w_cell[0]);
                    n_out_last  = (r_cnt == CntBits'(1));
                    w_op        = OP_POP;
                    n_cnt       = r_cnt - CntBits'(1);
                    if (r_cnt == CntBits'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_char;
    assign o_m_axis_tlast  = r_out_last;

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_cnt == '0))
        else $error("digit stack not empty while idle");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_cnt != '0))
        else $error("emitting from an empty digit stack");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_WAIT) |-> (r_cnt < CntBits'(StackDepth)))
        else $error("digit stack overflow");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (w_div_rem < w_base))
        else $error("divider remainder not below radix");

endmodule
